>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, off during reset
`define ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

>>> hdl/stq_pkg.sv
// Shared types and constants of the sorted timeout queue.
// No dependencies.
`default_nettype none
package stq_pkg;
  localparam int unsigned Depth = 16;
  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [62:0] Mask63 = {63{1'b1}};
  localparam logic [26:0] NsPerTenth = 27'd100000000;

  localparam logic [1:0] OP_SET = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_AGE = 2'd2;
  localparam logic [1:0] OP_GET = 2'd3;

  localparam logic [3:0] ST_SET_OK = 4'd0;
  localparam logic [3:0] ST_UNKNOWN = 4'd1;
  localparam logic [3:0] ST_FULL = 4'd2;
  localparam logic [3:0] ST_CLEARED = 4'd3;
  localparam logic [3:0] ST_CLEAR_MISS = 4'd4;
  localparam logic [3:0] ST_EXPIRED = 4'd5;
  localparam logic [3:0] ST_NEXT = 4'd6;
  localparam logic [3:0] ST_EMPTY = 4'd7;
  localparam logic [3:0] ST_FOUND = 4'd8;
  localparam logic [3:0] ST_NOT_FOUND = 4'd9;

  typedef struct packed {
    logic [1:0] op;
    logic [62:0] now_ns;
    logic [31:0] timer_ident;
    logic relative;
    logic [31:0] delay_tenths;
    logic [62:0] deadline_ns;
    logic [31:0] user_tag;
    logic [7:0] handler;
  } req_t;

  typedef struct packed {
    logic [3:0] status;
    logic [31:0] out_ident;
    logic [31:0] out_tag;
    logic [7:0] out_handler;
    logic [62:0] time_value;
    logic last;
  } rsp_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;        // capture request, reset scan index
    logic idx_clr;     // reset scan index to the head
    logic scan_step;   // advance scan index
    logic mul_step;    // register product
    logic calc_dl;     // register new deadline
    logic rm_step;     // shift one entry down at scan index
    logic rm_done;     // decrement count
    logic ins_init;    // start insert at count
    logic ins_step;    // shift one entry up or place new one
    logic take_id;     // advance id counter
    logic set_rsp;     // load response register
    logic [3:0] rsp_status;
    logic rsp_last;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic id_zero;
    logic scan_end;    // scan index reached count
    logic hit;         // entry at scan index matches id
    logic full;
    logic empty;
    logic head_expired;
    logic rm_end;      // removal shifted through the end
    logic ins_done;    // insert slot reached
  } sts_t;
endpackage
`default_nettype wire

>>> hdl/stq_if.sv
// Valid/ready channel carrying one payload.
// No dependencies.
`default_nettype none
interface stq_if #(parameter type T = logic) (input wire logic clk);
  logic valid;
  logic ready;
  T data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/stq_datapath.sv
// Datapath: timer table, scan and shift index, deadline arithmetic, result.
// Depends on stq_pkg.
`default_nettype none
module stq_datapath (
  input wire logic clk,
  input wire logic rst,
  input wire stq_pkg::req_t req,
  input wire stq_pkg::cmd_t cmd,
  output stq_pkg::sts_t sts,
  output stq_pkg::rsp_t rsp
);
  import stq_pkg::*;

  logic [62:0] tab_dl [Depth];
  logic [31:0] tab_id [Depth];
  logic [31:0] tab_tag [Depth];
  logic [7:0] tab_hd [Depth];
  logic [CntW-1:0] count;
  logic [31:0] next_ident;
  req_t r;
  logic [CntW-1:0] idx;
  logic [58:0] prod;
  logic [62:0] new_dl;
  logic [31:0] new_id;
  logic [IdxW-1:0] ix;
  logic [IdxW-1:0] ixm1;
  logic [IdxW-1:0] ixp1;
  logic [63:0] sum;
  logic ins_here;

  assign ix = idx[IdxW-1:0];
  assign ixm1 = ix - IdxW'(1);
  assign ixp1 = ix + IdxW'(1);
  assign sum = {1'b0, r.now_ns} + {5'd0, prod};
  // insert position: idx==0 or entry below has deadline <= new one
  assign ins_here = (idx == '0) || (tab_dl[ixm1] <= new_dl);

  always_comb begin
    sts.op = r.op;
    sts.id_zero = (r.timer_ident == '0);
    sts.scan_end = (idx >= count);
    sts.hit = (idx < count) && (tab_id[ix] == r.timer_ident);
    sts.full = (count >= CntW'(Depth));
    sts.empty = (count == '0);
    sts.head_expired = (count != '0) && (r.now_ns > tab_dl[0]);
    sts.rm_end = (idx + CntW'(1) >= count);
    sts.ins_done = ins_here;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      next_ident <= 32'd1;
    end else begin
      if (cmd.rm_done) count <= count - CntW'(1);
      if (cmd.ins_step && ins_here) count <= count + CntW'(1);
      if (cmd.take_id) next_ident <= (next_ident == '1) ? 32'd1 : next_ident + 32'd1;
    end
  end

  // request, index, arithmetic
  always_ff @(posedge clk) begin
    if (cmd.load) r <= req;
    if (cmd.load || cmd.idx_clr) idx <= '0;
    else if (cmd.scan_step) idx <= idx + CntW'(1);
    else if (cmd.rm_step) idx <= idx + CntW'(1);
    else if (cmd.ins_init) idx <= count;
    else if (cmd.ins_step && !ins_here) idx <= idx - CntW'(1);
    if (cmd.mul_step) prod <= 59'(r.delay_tenths * NsPerTenth);
    if (cmd.calc_dl) begin
      if (r.relative) new_dl <= sum[63] ? Mask63 : sum[62:0];
      else new_dl <= r.deadline_ns;
      new_id <= next_ident;
    end
  end

  // table shifts
  always_ff @(posedge clk) begin
    if (cmd.rm_step && !sts.rm_end) begin
      tab_dl[ix] <= tab_dl[ixp1];
      tab_id[ix] <= tab_id[ixp1];
      tab_tag[ix] <= tab_tag[ixp1];
      tab_hd[ix] <= tab_hd[ixp1];
    end
    if (cmd.ins_step) begin
      if (ins_here) begin
        tab_dl[ix] <= new_dl;
        tab_id[ix] <= new_id;
        tab_tag[ix] <= r.user_tag;
        tab_hd[ix] <= r.handler;
      end else begin
        tab_dl[ix] <= tab_dl[ixm1];
        tab_id[ix] <= tab_id[ixm1];
        tab_tag[ix] <= tab_tag[ixm1];
        tab_hd[ix] <= tab_hd[ixm1];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.set_rsp) begin
      rsp.status <= cmd.rsp_status;
      rsp.last <= cmd.rsp_last;
      rsp.out_ident <= '0;
      rsp.out_tag <= '0;
      rsp.out_handler <= '0;
      rsp.time_value <= '0;
      case (cmd.rsp_status)
        ST_SET_OK: rsp.out_ident <= new_id;
        ST_CLEARED: begin
          rsp.out_ident <= r.timer_ident;
          rsp.out_tag <= tab_tag[ix];
        end
        ST_EXPIRED: begin
          rsp.out_ident <= tab_id[0];
          rsp.out_tag <= tab_tag[0];
          rsp.out_handler <= tab_hd[0];
        end
        ST_NEXT: rsp.time_value <= tab_dl[0] - r.now_ns;
        ST_FOUND: rsp.time_value <= tab_dl[ix];
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> hdl/stq_ctrl.sv
// Controller state machine sequencing search, remove, insert and replies.
// Depends on stq_pkg.
`default_nettype none
module stq_ctrl (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input wire logic out_ready,
  input wire stq_pkg::sts_t sts,
  output stq_pkg::cmd_t cmd
);
  import stq_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_DISPATCH = 10'b0000000010,
    S_SEARCH = 10'b0000000100,
    S_REMOVE = 10'b0000001000,
    S_MUL = 10'b0000010000,
    S_CALC = 10'b0000100000,
    S_INSERT = 10'b0001000000,
    S_AGE = 10'b0010000000,
    S_OUT = 10'b0100000000,
    S_AGE_RM = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic done, done_next;  // result in S_OUT is final
  logic hit_seen, hit_seen_next;
  logic out_ok;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_ok = out_ready;

  always_comb begin
    state_next = state;
    done_next = done;
    hit_seen_next = hit_seen;
    cmd = '0;
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        hit_seen_next = 1'b0;
        if (sts.op == OP_AGE) state_next = S_AGE;
        else if (sts.op == OP_SET && sts.id_zero) begin
          if (sts.full) begin
            cmd.set_rsp = 1'b1;
            cmd.rsp_status = ST_FULL;
            cmd.rsp_last = 1'b1;
            state_next = S_OUT;
          end else state_next = S_MUL;
        end else if (sts.op == OP_CLEAR && sts.id_zero) begin
          cmd.set_rsp = 1'b1;
          cmd.rsp_status = ST_CLEAR_MISS;
          cmd.rsp_last = 1'b1;
          state_next = S_OUT;
        end else state_next = S_SEARCH;
        done_next = 1'b1;
      end
      S_SEARCH: begin
        if (sts.hit) begin
          cmd.set_rsp = 1'b1;
          cmd.rsp_last = 1'b1;
          case (sts.op)
            OP_GET: begin
              cmd.rsp_status = ST_FOUND;
              state_next = S_OUT;
            end
            OP_CLEAR: begin
              cmd.rsp_status = ST_CLEARED;
              state_next = S_REMOVE;
            end
            default: begin
              cmd.set_rsp = 1'b0;
              state_next = S_REMOVE;
            end
          endcase
        end else if (sts.scan_end) begin
          cmd.set_rsp = 1'b1;
          cmd.rsp_last = 1'b1;
          case (sts.op)
            OP_GET: cmd.rsp_status = ST_NOT_FOUND;
            OP_CLEAR: cmd.rsp_status = ST_CLEAR_MISS;
            default: cmd.rsp_status = ST_UNKNOWN;
          endcase
          state_next = S_OUT;
        end else cmd.scan_step = 1'b1;
      end
      S_REMOVE: begin
        cmd.rm_step = 1'b1;
        if (sts.rm_end) begin
          cmd.rm_done = 1'b1;
          state_next = (sts.op == OP_SET) ? S_MUL : S_OUT;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        state_next = S_CALC;
      end
      S_CALC: begin
        cmd.calc_dl = 1'b1;
        cmd.take_id = 1'b1;
        state_next = S_INSERT;
        hit_seen_next = 1'b0;
      end
      S_INSERT: begin
        if (!hit_seen) begin
          cmd.ins_init = 1'b1;
          hit_seen_next = 1'b1;
        end else begin
          cmd.ins_step = 1'b1;
          if (sts.ins_done) begin
            cmd.set_rsp = 1'b1;
            cmd.rsp_status = ST_SET_OK;
            cmd.rsp_last = 1'b1;
            state_next = S_OUT;
          end
        end
      end
      S_AGE: begin
        cmd.set_rsp = 1'b1;
        if (sts.head_expired) begin
          cmd.rsp_status = ST_EXPIRED;
          done_next = 1'b0;
        end else begin
          cmd.rsp_status = sts.empty ? ST_EMPTY : ST_NEXT;
          cmd.rsp_last = 1'b1;
          done_next = 1'b1;
        end
        state_next = S_OUT;
      end
      S_AGE_RM: begin
        cmd.rm_step = 1'b1;
        if (sts.rm_end) begin
          cmd.rm_done = 1'b1;
          state_next = S_AGE;
        end
      end
      S_OUT: if (out_ok) begin
        if (done) state_next = S_IDLE;
        else begin
          // expired head leaves next: removal starts at slot 0
          cmd.idx_clr = 1'b1;
          state_next = S_AGE_RM;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b1;
      hit_seen <= 1'b0;
    end else begin
      state <= state_next;
      done <= done_next;
      hit_seen <= hit_seen_next;
    end
  end
endmodule
`default_nettype wire

>>> hdl/sorted_timeout_queue.sv
// Sorted timeout queue: top level joining controller and datapath.
// Depends on stq_pkg, stq_if, stq_ctrl, stq_datapath, assert_macros.svh.
//
// Usage: requests arrive on the req channel (valid/ready); each gives one
// or more results on the rsp channel, the final one flagged by last.
// One request at a time: req.ready is high only while idle.
// Get/clear/re-arm scan the table one entry per cycle; removal and
// insertion shift one entry per cycle. An age request gives one result
// per expired timer, removing each in turn, plus a final one.
// A stalled receiver holds the result register and the sequencer; nothing
// is lost. Reset empties the queue and restarts ids at 1; table contents
// are not cleared, only the count.
`default_nettype none
`include "assert_macros.svh"
module sorted_timeout_queue (
  input wire logic clk,
  input wire logic rst,
  stq_if.sink req,
  stq_if.source rsp
);
  import stq_pkg::*;

  cmd_t cmd;
  sts_t sts;
  rsp_t rsp_q;

  stq_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .sts(sts), .cmd(cmd)
  );

  stq_datapath u_dp (
    .clk(clk), .rst(rst), .req(req.data), .cmd(cmd), .sts(sts), .rsp(rsp_q)
  );

  assign rsp.data = rsp_q;

  `ASSERT_IMP(a_no_overlap, clk, rst, req.ready, !rsp.valid)
  `ASSERT_NEXT(a_hold, clk, rst, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.data))
  `ASSERT_IMP(a_last_status, clk, rst, rsp.valid && !rsp.data.last,
    rsp.data.status == ST_EXPIRED)
endmodule
`default_nettype wire
